// ===== hw/rtl/sbbi_pkg.sv =====
// shared types, constants and the sigmoid table for the beam bin intensity block
`timescale 1ns / 1ps
package sbbi_pkg;

    localparam int MAX_BINS    = 64;
    localparam int BIN_W       = 6;
    localparam int NB_W        = 7;
    localparam int SIG_ENTRIES = 1024;
    localparam int SIG_AW      = 10;
    localparam int NORMAL_W    = 16;
    localparam int DEPTH_W     = 17;
    localparam int INTENS_W    = 16;
    localparam int COUNT_W     = 17;
    localparam int SUM_W       = 33;
    localparam int ACC_W       = COUNT_W + SUM_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [DEPTH_W-1:0]  DEPTH_ONE  = DEPTH_W'(65536);
    localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
    localparam logic [NB_W-1:0]     BINS_RESET = NB_W'(MAX_BINS);
    localparam logic [63:0]         ONE_Q30    = 64'd1 << 30;

    typedef struct packed {
        logic [NORMAL_W-1:0] normal_value;
        logic [DEPTH_W-1:0]  depth_value;
        logic                last_pixel;
    } t_pix_in;

    typedef struct packed {
        logic [BIN_W-1:0]    bin_index;
        logic [INTENS_W-1:0] bin_intensity;
        logic                last_bin;
    } t_bin_out;

    // one classified pixel handed from front to back
    typedef struct packed {
        logic [BIN_W-1:0]    bin;
        logic [INTENS_W-1:0] sig;
        logic                last;
    } t_work;

    typedef logic [INTENS_W-1:0] t_sig_tab [SIG_ENTRIES];

    // bitwise long division, used only while building the table
    function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-a) in q30: taylor series at a/16, then squared four times
    function automatic logic [63:0] f_exp_neg(input logic [63:0] a_q30);
        logic [63:0]        r;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic [63:0]        v;
        r    = a_q30 >> 4;
        term = ONE_Q30;
        acc  = $signed(ONE_Q30);
        for (int n = 1; n <= 10; n++) begin
            term = f_udiv(term * r, 64'(n) << 30);
            if (n % 2 == 1) begin
                acc = acc - $signed(term);
            end else begin
                acc = acc + $signed(term);
            end
        end
        v = (acc < 0) ? 64'd0 : $unsigned(acc);
        for (int n = 0; n < 4; n++) begin
            v = (v * v) >> 30;
        end
        return v;
    endfunction

    function automatic logic [INTENS_W-1:0] f_sig(input int i);
        logic signed [63:0] d;
        logic [63:0]        mag;
        logic [63:0]        a;
        logic [63:0]        e;
        logic [63:0]        den;
        logic [63:0]        s;
        d   = 64'(18 * i) - 64'(12 * SIG_ENTRIES);
        mag = (d < 0) ? $unsigned(-d) : $unsigned(d);
        a   = (mag << 30) / SIG_ENTRIES;
        e   = f_exp_neg(a);
        den = ONE_Q30 + e;
        if (d >= 0) begin
            s = (f_udiv(64'd1 << 47, den) + 64'd1) >> 1;
        end else begin
            s = (f_udiv(e << 17, den) + 64'd1) >> 1;
        end
        if (s > 64'd65535) begin
            s = 64'd65535;
        end
        return s[INTENS_W-1:0];
    endfunction

    function automatic t_sig_tab f_sig_table();
        t_sig_tab tab;
        for (int i = 0; i < SIG_ENTRIES; i++) begin
            tab[i] = f_sig(i);
        end
        return tab;
    endfunction

    localparam t_sig_tab SIG_TAB = f_sig_table();

endpackage

// ===== hw/rtl/sonar_beam_bin_intensity_top.sv =====
// top level of the sonar beam range bin intensity block
//
// channel  | handshake                 | beat
// ---------+---------------------------+-------------------------------------
// in       | i_in_valid / o_in_ready   | t_pix_in: normal, depth, last pixel
// out      | o_out_valid / i_out_ready | t_bin_out: bin, mean intensity, last
// cfg      | i_cfg_valid / o_cfg_ready | bins_in_use, 7 bits, always ready
//
// the back end handles a pixel as an accumulator ram read, then write, and
// takes no new pixel before that. the front end takes one pixel per cycle
// into a 4 deep queue while it has room. the last pixel starts readout:
// per bin: ram read, 33 step serial divider, output beat with any stall.
// synchronous active low reset clears control and the bin valid bits.
`timescale 1ns / 1ps
module sonar_beam_bin_intensity_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sbbi_pkg::t_pix_in    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sbbi_pkg::t_bin_out   o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [sbbi_pkg::NB_W-1:0] i_cfg_data
);
    import sbbi_pkg::*;

    logic [NB_W-1:0] r_bins;
    logic [NB_W-1:0] nb;
    logic            f_valid;
    logic            f_ready;
    t_work           f_wk;
    logic            q_valid;
    logic            q_ready;
    t_work           q_wk;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins <= BINS_RESET;
        end else if (i_cfg_valid) begin
            r_bins <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_bins == '0) begin
            nb = NB_W'(1);
        end else if (r_bins > NB_W'(MAX_BINS)) begin
            nb = NB_W'(MAX_BINS);
        end else begin
            nb = r_bins;
        end
    end

    sbbi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_nb       (nb),
        .o_wk_valid (f_valid),
        .i_wk_ready (f_ready),
        .o_wk       (f_wk)
    );

    sbbi_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push       (f_wk),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop        (q_wk)
    );

    sbbi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wk_valid  (q_valid),
        .o_wk_ready  (q_ready),
        .i_wk        (q_wk),
        .i_nb        (nb),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );
endmodule

// ===== hw/rtl/sbbi_ram.sv =====
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module sbbi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/sbbi_front.sv =====
// front end: sigmoid lookup and range bin selection per pixel
`timescale 1ns / 1ps
module sbbi_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sbbi_pkg::t_pix_in    i_in_data,
    input  logic [sbbi_pkg::NB_W-1:0] i_nb,
    output logic                 o_wk_valid,
    input  logic                 i_wk_ready,
    output sbbi_pkg::t_work      o_wk
);
    import sbbi_pkg::*;

    logic                    r_valid;
    logic                    n_valid;
    t_work                   r_wk;
    logic                    take;
    logic [DEPTH_W-1:0]      depth_sat;
    logic [BIN_W-1:0]        nb_m1;
    logic [DEPTH_W+BIN_W-1:0] prod;
    logic [SIG_AW-1:0]       sig_idx;

    always_comb begin
        o_in_ready = !r_valid || i_wk_ready;
        take       = i_in_valid && o_in_ready;
        depth_sat  = (i_in_data.depth_value > DEPTH_ONE) ? DEPTH_ONE : i_in_data.depth_value;
        nb_m1      = BIN_W'(i_nb - NB_W'(1));
        prod       = (DEPTH_W+BIN_W)'(depth_sat) * (DEPTH_W+BIN_W)'(nb_m1);
        sig_idx    = i_in_data.normal_value[NORMAL_W-1 -: SIG_AW];
        if (take) begin
            n_valid = 1'b1;
        end else if (i_wk_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // table read is registered like a rom
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_wk.bin  <= prod[DEPTH_W-1 +: BIN_W];
            r_wk.sig  <= SIG_TAB[sig_idx];
            r_wk.last <= i_in_data.last_pixel;
        end
    end

    assign o_wk_valid = r_valid;
    assign o_wk       = r_wk;
endmodule

// ===== hw/rtl/sbbi_queue.sv =====
// short fifo between the front and back ends
`timescale 1ns / 1ps
module sbbi_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  sbbi_pkg::t_work i_push,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output sbbi_pkg::t_work o_pop
);
    import sbbi_pkg::*;

    t_work                 r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wptr;
    logic [QUEUE_AW-1:0]   r_rptr;
    logic [QUEUE_AW:0]     r_fill;
    logic                  push;
    logic                  pop;

    always_comb begin
        o_push_ready = r_fill != (QUEUE_AW+1)'(QUEUE_DEPTH);
        o_pop_valid  = r_fill != '0;
        push         = i_push_valid && o_push_ready;
        pop          = o_pop_valid && i_pop_ready;
        o_pop        = r_slot[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + QUEUE_AW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + QUEUE_AW'(1);
            end
            if (push && !pop) begin
                r_fill <= r_fill + (QUEUE_AW+1)'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - (QUEUE_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= i_push;
        end
    end
endmodule

// ===== hw/rtl/sbbi_back.sv =====
// back end: per bin accumulation and end of beam readout with serial divide
`timescale 1ns / 1ps
module sbbi_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wk_valid,
    output logic                      o_wk_ready,
    input  sbbi_pkg::t_work           i_wk,
    input  logic [sbbi_pkg::NB_W-1:0] i_nb,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output sbbi_pkg::t_bin_out        o_out_data
);
    import sbbi_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ACC   = 6'b000010,
        ST_RO_RD = 6'b000100,
        ST_RO_LD = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [MAX_BINS-1:0] r_vld;
    logic                r_rd_vld;
    logic [BIN_W-1:0]    r_bin;
    logic [INTENS_W-1:0] r_sig;
    logic                r_last;
    logic [NB_W-1:0]     r_k;
    logic [SUM_W-1:0]    r_num;
    logic [COUNT_W-1:0]  r_den;
    logic [COUNT_W:0]    r_rem;
    logic [5:0]          r_step;
    t_bin_out            r_out;

    logic                we;
    logic [BIN_W-1:0]    waddr;
    logic [ACC_W-1:0]    wdata;
    logic [BIN_W-1:0]    raddr;
    logic [ACC_W-1:0]    rdata;
    logic [COUNT_W-1:0]  cur_cnt;
    logic [SUM_W-1:0]    cur_sum;
    logic [COUNT_W:0]    rem_sh;
    logic                fits;
    logic                k_last;

    sbbi_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_BINS)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        // entries never written since the last clear read as zero
        cur_cnt = r_rd_vld ? rdata[ACC_W-1 -: COUNT_W] : '0;
        cur_sum = r_rd_vld ? rdata[SUM_W-1:0] : '0;
        rem_sh  = {r_rem[COUNT_W-1:0], r_num[SUM_W-1]};
        fits    = rem_sh >= {1'b0, r_den};
        k_last  = r_k == (i_nb - NB_W'(1));
        o_wk_ready = r_state == ST_IDLE;
        raddr   = (r_state == ST_IDLE) ? i_wk.bin : r_k[BIN_W-1:0];
        we      = 1'b0;
        waddr   = r_bin;
        wdata   = {cur_cnt + COUNT_W'(1), cur_sum + SUM_W'(r_sig)};
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_wk_valid) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                we = cur_cnt != COUNT_MAX;
                n_state = r_last ? ST_RO_RD : ST_IDLE;
            end
            ST_RO_RD: begin
                n_state = ST_RO_LD;
            end
            ST_RO_LD: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_step == 6'(SUM_W - 1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = k_last ? ST_IDLE : ST_RO_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_vld   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (we) begin
                r_vld[r_bin] <= 1'b1;
            end
            if (r_state == ST_RO_LD) begin
                r_vld[r_k[BIN_W-1:0]] <= 1'b0;
            end
            if (r_state == ST_ACC && r_last) begin
                r_k <= '0;
            end else if (r_state == ST_OUT && i_out_ready) begin
                r_k <= r_k + NB_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_vld[raddr];
        if (r_state == ST_IDLE && i_wk_valid) begin
            r_bin  <= i_wk.bin;
            r_sig  <= i_wk.sig;
            r_last <= i_wk.last;
        end
        if (r_state == ST_RO_LD) begin
            r_num  <= cur_sum;
            r_den  <= cur_cnt;
            r_rem  <= '0;
            r_step <= '0;
        end
        // restoring divide, one quotient bit per cycle, shifted into r_num
        if (r_state == ST_DIV) begin
            r_rem  <= fits ? rem_sh - {1'b0, r_den} : rem_sh;
            r_num  <= {r_num[SUM_W-2:0], fits};
            r_step <= r_step + 6'd1;
            if (r_step == 6'(SUM_W - 1)) begin
                r_out.bin_index     <= r_k[BIN_W-1:0];
                r_out.bin_intensity <= (r_den == '0) ? '0 :
                                       {r_num[INTENS_W-2:0], fits};
                r_out.last_bin      <= k_last;
            end
        end
    end

    assign o_out_valid = r_state == ST_OUT;
    assign o_out_data  = r_out;
endmodule

// ===== tb/sonar_beam_bin_intensity_checker.sv =====
// checker for the beam bin intensity block: predicts bin readouts and compares them
`timescale 1ns / 1ps
module sonar_beam_bin_intensity_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  sbbi_pkg::t_pix_in             i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  sbbi_pkg::t_bin_out            i_out_data,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [sbbi_pkg::NB_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import sbbi_pkg::*;

    logic [INTENS_W-1:0] sig_lut [SIG_ENTRIES];
    logic [COUNT_W-1:0]  pix_count [MAX_BINS];
    logic [SUM_W-1:0]    sig_sum [MAX_BINS];
    logic [NB_W-1:0]     bins_reg;
    t_bin_out            bin_results_q [$];
    int                  fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = bin_results_q.size();

    // exp(-a) in q30: series at a/16, squared four times
    function automatic longint unsigned exp_neg(input longint unsigned a);
        longint unsigned r;
        longint unsigned term;
        longint          acc;
        longint unsigned v;
        r    = a >> 4;
        term = 64'd1 << 30;
        acc  = 64'sd1 << 30;
        for (int n = 1; n <= 10; n++) begin
            term = (term * r) / (longint'(n) << 30);
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        v = (acc < 0) ? 64'd0 : longint'(acc);
        for (int n = 0; n < 4; n++) begin
            v = (v * v) >> 30;
        end
        return v;
    endfunction

    function automatic logic [INTENS_W-1:0] sigmoid_entry(input int i);
        longint          d;
        longint unsigned mag;
        longint unsigned e;
        longint unsigned den;
        longint unsigned s;
        d   = 18 * longint'(i) - 12 * longint'(SIG_ENTRIES);
        mag = (d < 0) ? -d : d;
        e   = exp_neg((mag << 30) / SIG_ENTRIES);
        den = (64'd1 << 30) + e;
        if (d >= 0) begin
            s = (((64'd1 << 47) / den) + 1) >> 1;
        end else begin
            s = (((e << 17) / den) + 1) >> 1;
        end
        if (s > 65535) begin
            s = 65535;
        end
        return s[INTENS_W-1:0];
    endfunction

    initial begin
        for (int i = 0; i < SIG_ENTRIES; i++) begin
            sig_lut[i] = sigmoid_entry(i);
        end
    end

    function automatic int eff_bins();
        int nb;
        nb = bins_reg;
        if (nb < 1) begin
            nb = 1;
        end
        if (nb > MAX_BINS) begin
            nb = MAX_BINS;
        end
        return nb;
    endfunction

    task automatic clear_bins();
        for (int k = 0; k < MAX_BINS; k++) begin
            pix_count[k] = '0;
            sig_sum[k]   = '0;
        end
    endtask

    // accumulate one pixel; on the last pixel queue the whole beam readout
    task automatic accumulate_pixel(input t_pix_in p);
        int              nb;
        longint unsigned depth;
        int              bin;
        t_bin_out        r;
        nb    = eff_bins();
        depth = p.depth_value;
        if (depth > 65536) begin
            depth = 65536;
        end
        bin = int'((depth * longint'(nb - 1)) >> 16);
        if (bin >= MAX_BINS) begin
            bin = MAX_BINS - 1;
        end
        if (pix_count[bin] != COUNT_MAX) begin
            pix_count[bin] = pix_count[bin] + 1'b1;
            sig_sum[bin]   = sig_sum[bin] + sig_lut[p.normal_value >> 6];
        end
        if (p.last_pixel) begin
            for (int k = 0; k < nb; k++) begin
                r.bin_index     = BIN_W'(k);
                r.bin_intensity = (pix_count[k] == 0) ? '0
                                  : INTENS_W'(sig_sum[k] / pix_count[k]);
                r.last_bin      = (k == nb - 1);
                bin_results_q   = {bin_results_q, r};
            end
            clear_bins();
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_bin_out want;
        if (!i_rst_n) begin
            clear_bins();
            bins_reg = BINS_RESET;
            bin_results_q.delete();
            fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (bin_results_q.size() == 0) begin
                    report_mismatch("unexpected result beat, bin", i_out_data.bin_index, -1);
                end else begin
                    want = bin_results_q.pop_front();
                    if (i_out_data.bin_index != want.bin_index)
                        report_mismatch("bin_index", i_out_data.bin_index, want.bin_index);
                    if (i_out_data.bin_intensity != want.bin_intensity)
                        report_mismatch("bin_intensity", i_out_data.bin_intensity,
                                        want.bin_intensity);
                    if (i_out_data.last_bin != want.last_bin)
                        report_mismatch("last_bin", i_out_data.last_bin, want.last_bin);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                bins_reg = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                accumulate_pixel(i_in_data);
            end
        end
    end
endmodule

// ===== tb/tb_sonar_beam_bin_intensity_top.sv =====
// testbench top: drives pixel beams and bin count settings, gives the verdict
`timescale 1ns / 1ps
module tb_sonar_beam_bin_intensity_top;
    import sbbi_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_pix_in           i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    t_bin_out          o_out_data;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [NB_W-1:0]   i_cfg_data;
    int                fail_count;
    int                pending;
    int                idle_pct;
    int                stall_pct;

    sonar_beam_bin_intensity_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    sonar_beam_bin_intensity_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("sonar_beam_bin_intensity_top: mismatch");
        $finish;
    end

    // receiver side stalls at the rate of the current phase
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_pixel(input logic [NORMAL_W-1:0] nv, input logic [DEPTH_W-1:0] dv,
                              input logic lp);
        logic ok;
        if ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{normal_value: nv, depth_value: dv, last_pixel: lp};
        // ready only moves at the rising edge, so look at it mid cycle
        do begin
            @(negedge i_clk);
            ok = o_in_ready;
            @(posedge i_clk);
        end while (!ok);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        // let the checker take in the last accepted beat first
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_bins(input logic [NB_W-1:0] nb);
        logic ok;
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= nb;
        do begin
            @(negedge i_clk);
            ok = o_cfg_ready;
            @(posedge i_clk);
        end while (!ok);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_beams(input int n_items);
        int sent;
        int len;
        logic [DEPTH_W-1:0] dv;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 8);
            for (int j = 0; j < len; j++) begin
                dv = ($urandom_range(0, 7) == 0) ? DEPTH_W'($urandom)
                                                 : DEPTH_W'($urandom_range(0, 65536));
                send_pixel(NORMAL_W'($urandom), dv, j == len - 1);
            end
            sent += len;
            if ($urandom_range(0, 5) == 0) begin
                wait_drained();
            end
        end
    endtask

    initial begin
        int nb_pick;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset bin count, field extremes and depth above one
        send_pixel(16'h0000, 17'd0, 1'b0);
        send_pixel(16'hffff, 17'd65536, 1'b0);
        send_pixel(16'hffc0, 17'h1ffff, 1'b0);
        send_pixel(16'haaaa, 17'd65535, 1'b0);
        send_pixel(16'h5555, 17'd32768, 1'b0);
        send_pixel(16'haaab, 17'd1024, 1'b1);
        // last pixel alone, all other bins empty
        send_pixel(16'h8000, 17'd40000, 1'b1);
        set_bins(7'd2);
        send_pixel(16'h003f, 17'd0, 1'b0);
        send_pixel(16'hffff, 17'd0, 1'b1);
        send_pixel(16'h1234, 17'd65536, 1'b0);
        send_pixel(16'hfedc, 17'd70000, 1'b1);
        set_bins(7'd1);
        send_pixel(16'hc000, 17'd65536, 1'b0);
        send_pixel(16'h7fff, 17'd12345, 1'b1);
        set_bins(7'd0);
        send_pixel(16'h4000, 17'h1ffff, 1'b1);
        set_bins(7'd127);
        send_pixel(16'hf000, 17'd65536, 1'b0);
        send_pixel(16'h0100, 17'd65535, 1'b1);
        set_bins(7'd65);
        send_pixel(16'hffff, 17'd1040, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            nb_pick = $urandom_range(0, 3);
            set_bins(nb_pick == 0 ? 7'd2 : nb_pick == 1 ? 7'd64
                                         : NB_W'($urandom_range(0, 127)));
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 66; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 66; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            random_beams(22);
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("sonar_beam_bin_intensity_top: match");
        end else begin
            $display("sonar_beam_bin_intensity_top: mismatch");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/sbbi_pkg.sv
hw/rtl/sbbi_ram.sv
hw/rtl/sbbi_front.sv
hw/rtl/sbbi_queue.sv
hw/rtl/sbbi_back.sv
hw/rtl/sonar_beam_bin_intensity_top.sv
tb/sonar_beam_bin_intensity_checker.sv
tb/tb_sonar_beam_bin_intensity_top.sv
